// ===== rtl/thfra_pkg.sv =====
// Package for the thermal frame region average block.
// Holds field widths, config register codes, the config struct and region byte positions.
// No dependencies.
package thfra_pkg;

    localparam int BYTE_W = 8;
    localparam int PIX_W  = 16;
    localparam int SUM_W  = 18;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [BYTE_W-1:0] SYNC_BYTE_RST  = 8'd242;
    localparam logic [PIX_W-1:0]  HOT_LIMIT_RST  = 16'd900;
    localparam logic [PIX_W-1:0]  HOT_SUBST_RST  = 16'd300;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SYNC_BYTE = 2'd0,
        CFG_HOT_LIMIT = 2'd1,
        CFG_HOT_SUBST = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [BYTE_W-1:0] sync_byte;
        logic [PIX_W-1:0]  hot_limit;
        logic [PIX_W-1:0]  hot_substitute;
    } cfg_t;

    // frame byte positions of the high bytes of pixels 5, 6, 9 and 10
    localparam int REGION_PIX = 4;
    localparam int REGION_HI_BYTE [REGION_PIX] = '{13, 15, 21, 23};

    typedef enum logic [3:0] {
        PH_HUNT  = 4'b0001,
        PH_LEFT  = 4'b0010,
        PH_RIGHT = 4'b0100,
        PH_TAIL  = 4'b1000
    } phase_t;

endpackage

// ===== rtl/thfra_cfg.sv =====
// Configuration registers of the thermal frame region average block.
// Depends on thfra_pkg.
module thfra_cfg
    import thfra_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_SYNC_BYTE: cfg_next.sync_byte      = cfg_data[BYTE_W-1:0];
                CFG_HOT_LIMIT: cfg_next.hot_limit      = cfg_data[PIX_W-1:0];
                CFG_HOT_SUBST: cfg_next.hot_substitute = cfg_data[PIX_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_byte      <= SYNC_BYTE_RST;
            cfg_reg.hot_limit      <= HOT_LIMIT_RST;
            cfg_reg.hot_substitute <= HOT_SUBST_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== rtl/thfra_in_reg.sv =====
// Input register of the thermal frame region average block.
// Depends on thfra_pkg.
module thfra_in_reg
    import thfra_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [BYTE_W-1:0] data_byte,
    input  logic              advance,
    output logic              item_vld,
    output logic [BYTE_W-1:0] item_byte
);

    logic              vld_reg;
    logic              vld_next;
    logic [BYTE_W-1:0] byte_reg;

    assign in_stall  = vld_reg & ~advance;
    assign item_vld  = vld_reg;
    assign item_byte = byte_reg;

    always_comb
    begin
        vld_next = in_stall ? 1'b1 : in_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            byte_reg <= data_byte;
        end
    end

endmodule

// ===== rtl/thfra_core.sv =====
// Frame parser, region accumulator and result register.
// Depends on thfra_pkg.
module thfra_core
    import thfra_pkg::*;
#(
    parameter int PREAMBLE_LEN = 5,
    parameter int FRAME_BYTES  = 35,
    parameter int TAIL_BYTES   = 5
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              item_vld,
    input  logic [BYTE_W-1:0] item_byte,
    output logic              advance,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              side,
    output logic [SUM_W-1:0]  region_sum
);

    localparam int CW = $clog2(PREAMBLE_LEN + 1);
    localparam int IW = $clog2(FRAME_BYTES);

    phase_t            phase_reg, phase_next;
    logic [CW-1:0]     sync_cnt_reg, sync_cnt_next;
    logic [IW-1:0]     idx_reg, idx_next;
    logic [BYTE_W-1:0] low_hold_reg, low_hold_next;
    logic [SUM_W-1:0]  acc_reg, acc_next;
    logic              out_vld_reg, out_vld_next;
    logic              side_reg, side_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;

    logic              frame;
    logic              produce;
    logic              region_hi;
    logic [PIX_W-1:0]  pix;
    logic [PIX_W-1:0]  pix_clamp;
    logic [SUM_W-1:0]  acc_base;
    logic [SUM_W-1:0]  acc_add;
    logic [CW-1:0]     cnt_inc;
    logic [IW-1:0]     idx_inc;

    assign out_valid  = out_vld_reg;
    assign side       = side_reg;
    assign region_sum = sum_reg;

    assign frame   = (phase_reg == PH_LEFT) || (phase_reg == PH_RIGHT);
    assign produce = frame && (idx_reg >= IW'(FRAME_BYTES - 1));
    assign advance = item_vld && (!produce || !out_vld_reg || !out_stall);

    assign cnt_inc   = sync_cnt_reg + 1'b1;
    assign idx_inc   = idx_reg + 1'b1;
    assign pix       = {item_byte, low_hold_reg};
    assign pix_clamp = (pix >= cfg.hot_limit) ? cfg.hot_substitute : pix;
    assign acc_base  = (idx_reg == '0) ? '0 : acc_reg;

    always_comb
    begin
        region_hi = 1'b0;
        for (int k = 0; k < REGION_PIX; k++)
        begin
            if (int'(idx_reg) == REGION_HI_BYTE[k])
            begin
                region_hi = 1'b1;
            end
        end
    end

    assign acc_add = region_hi ? acc_base + SUM_W'(pix_clamp) : acc_base;

    always_comb
    begin
        phase_next    = phase_reg;
        sync_cnt_next = sync_cnt_reg;
        idx_next      = idx_reg;
        low_hold_next = low_hold_reg;
        acc_next      = acc_reg;
        side_next     = side_reg;
        sum_next      = sum_reg;
        out_vld_next  = out_vld_reg & out_stall;

        if (advance)
        begin
            unique case (phase_reg)
                PH_HUNT:
                begin
                    if (item_byte == cfg.sync_byte)
                    begin
                        if (cnt_inc >= CW'(PREAMBLE_LEN))
                        begin
                            sync_cnt_next = '0;
                            phase_next    = PH_LEFT;
                            idx_next      = '0;
                            acc_next      = '0;
                        end
                        else
                        begin
                            sync_cnt_next = cnt_inc;
                        end
                    end
                    else
                    begin
                        sync_cnt_next = '0;
                    end
                end
                PH_TAIL:
                begin
                    if (idx_inc >= IW'(TAIL_BYTES))
                    begin
                        phase_next = PH_HUNT;
                        idx_next   = '0;
                    end
                    else
                    begin
                        idx_next = idx_inc;
                    end
                end
                PH_LEFT, PH_RIGHT:
                begin
                    if (idx_reg >= IW'(2) && !idx_reg[0])
                    begin
                        low_hold_next = item_byte;
                    end
                    acc_next = acc_add;
                    if (produce)
                    begin
                        out_vld_next = 1'b1;
                        side_next    = (phase_reg == PH_RIGHT);
                        sum_next     = acc_add;
                        idx_next     = '0;
                        acc_next     = '0;
                        if (phase_reg == PH_LEFT)
                        begin
                            phase_next = PH_RIGHT;
                        end
                        else if (TAIL_BYTES > 0)
                        begin
                            phase_next = PH_TAIL;
                        end
                        else
                        begin
                            phase_next = PH_HUNT;
                        end
                    end
                    else
                    begin
                        idx_next = idx_inc;
                    end
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HUNT;
            sync_cnt_reg <= '0;
            idx_reg      <= '0;
            low_hold_reg <= '0;
            acc_reg      <= '0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            sync_cnt_reg <= sync_cnt_next;
            idx_reg      <= idx_next;
            low_hold_reg <= low_hold_next;
            acc_reg      <= acc_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg <= side_next;
        sum_reg  <= sum_next;
    end

endmodule

// ===== rtl/thermal_frame_region_average.sv =====
// Top level of the thermal frame region average block.
// Depends on thfra_pkg, thfra_cfg, thfra_in_reg and thfra_core.
//
//   channel   handshake               payload
//   in        in_valid / in_stall     data_byte
//   out       out_valid / out_stall   side, region_sum
//   cfg       cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One byte per cycle while in_stall is low; a frame's last byte passes the input register,
// then reaches the result register.
// The rate is set by the single pass from the input register to the result register.
// Reset clears parser state and loads config defaults; no clearing pass.
// A stalled result blocks only the byte that would produce the next result.
module thermal_frame_region_average
    import thfra_pkg::*;
#(
    parameter int PREAMBLE_LEN = 5,
    parameter int FRAME_BYTES  = 35,
    parameter int TAIL_BYTES   = 5
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [BYTE_W-1:0]     data_byte,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  side,
    output logic [SUM_W-1:0]      region_sum,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t              cfg;
    logic              advance;
    logic              item_vld;
    logic [BYTE_W-1:0] item_byte;

    thfra_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    thfra_in_reg u_in_reg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .advance   (advance),
        .item_vld  (item_vld),
        .item_byte (item_byte)
    );

    thfra_core
    #(
        .PREAMBLE_LEN (PREAMBLE_LEN),
        .FRAME_BYTES  (FRAME_BYTES),
        .TAIL_BYTES   (TAIL_BYTES)
    )
    u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_vld   (item_vld),
        .item_byte  (item_byte),
        .advance    (advance),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .side       (side),
        .region_sum (region_sum)
    );

endmodule

// ===== tb/thermal_frame_region_average_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for thermal_frame_region_average: directed frame table, then random
// packets with random idling on both sides; sums scored against the table or the built-in parser.
// Depends on thfra_pkg and the thermal_frame_region_average RTL.
module thermal_frame_region_average_test
    import thfra_pkg::*;
();

    localparam int PREAMBLE_LEN = 5;
    localparam int FRAME_BYTES  = 35;
    localparam int TAIL_BYTES   = 5;
    localparam int SETTLE       = 8;
    localparam int LONG_HOLD    = 150;
    localparam int QUIET_LIMIT  = 2000;
    localparam int RAND_BYTES   = 200;
    localparam int REGION_PIXEL [4] = '{5, 6, 9, 10};
    localparam cfg_idx_t CFG_SPARE = cfg_idx_t'(2'd3);

    typedef logic [3:0][PIX_W-1:0] pix_set_t;

    typedef struct packed {
        logic             side;
        logic [SUM_W-1:0] sum;
    } region_result_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              typed;
        region_result_t    want;
    } feed_t;

    typedef enum logic {ROW_REG, ROW_PKT} row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        cfg_idx_t              idx;
        logic [CFG_DATA_W-1:0] val;
        logic [3:0]            n_sync;
        logic                  broken;
        pix_set_t              left_pix;
        pix_set_t              right_pix;
        logic [BYTE_W-1:0]     fill;
        logic                  rnd_fill;
        logic                  typed;
        logic [SUM_W-1:0]      left_sum;
        logic [SUM_W-1:0]      right_sum;
    } row_t;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    logic [BYTE_W-1:0]     data_byte = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  side;
    logic [SUM_W-1:0]      region_sum;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    cfg_idx_t              cfg_index = CFG_SYNC_BYTE;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    feed_t          offer = '0;
    feed_t          feed_q [$];
    region_result_t sums_due [$];
    row_t           dir_rows [$];

    cfg_t             shadow   = '{SYNC_BYTE_RST, HOT_LIMIT_RST, HOT_SUBST_RST};
    phase_t           ph       = PH_HUNT;
    logic [2:0]       sync_run = '0;
    logic [5:0]       pos      = '0;
    logic [7:0]       low_hold = '0;
    logic [SUM_W-1:0] acc      = '0;

    bit calm         = 1'b0;
    int hold_asks    = 0;
    int hold_done    = 0;
    int errors       = 0;
    int bytes_taken  = 0;
    int quiet        = 0;

    thermal_frame_region_average #(
        .PREAMBLE_LEN (PREAMBLE_LEN),
        .FRAME_BYTES  (FRAME_BYTES),
        .TAIL_BYTES   (TAIL_BYTES)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .side       (side),
        .region_sum (region_sum),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic parse_byte(input logic [BYTE_W-1:0] b, output region_result_t res);
        logic [5:0]       off;
        logic [PIX_W-1:0] v;
        res = '0;
        if (ph == PH_HUNT)
        begin
            if (b == shadow.sync_byte)
            begin
                sync_run = sync_run + 3'd1;
                if (sync_run >= PREAMBLE_LEN)
                begin
                    sync_run = '0;
                    ph       = PH_LEFT;
                    pos      = '0;
                    acc      = '0;
                end
            end
            else
                sync_run = '0;
            return 1'b0;
        end
        if (ph == PH_TAIL)
        begin
            pos = pos + 6'd1;
            if (pos >= TAIL_BYTES)
            begin
                ph  = PH_HUNT;
                pos = '0;
            end
            return 1'b0;
        end
        if (pos == 0)
            acc = '0;
        if (pos >= 2)
        begin
            off = pos - 6'd2;
            if (!off[0])
                low_hold = b;
            else if (off[5:1] inside {5, 6, 9, 10})
            begin
                v = {b, low_hold};
                if (v >= shadow.hot_limit)
                    v = shadow.hot_substitute;
                acc = acc + SUM_W'(v);
            end
        end
        if (pos >= FRAME_BYTES - 1)
        begin
            res.side = (ph == PH_RIGHT);
            res.sum  = acc;
            pos      = '0;
            acc      = '0;
            if (ph == PH_LEFT)
                ph = PH_RIGHT;
            else if (TAIL_BYTES > 0)
                ph = PH_TAIL;
            else
                ph = PH_HUNT;
            return 1'b1;
        end
        pos = pos + 6'd1;
        return 1'b0;
    endfunction

    always @(posedge clk)
    begin
        region_result_t got;
        region_result_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_SYNC_BYTE: shadow.sync_byte      = cfg_data[BYTE_W-1:0];
                    CFG_HOT_LIMIT: shadow.hot_limit      = cfg_data;
                    CFG_HOT_SUBST: shadow.hot_substitute = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                bytes_taken++;
                if (parse_byte(data_byte, got))
                begin
                    if (offer.typed)
                        sums_due.push_back(offer.want);
                    else
                        sums_due.push_back(got);
                end
            end
            if (out_valid && !out_stall)
            begin
                if (sums_due.size() == 0)
                begin
                    $error("result with nothing pending: side %0d, region_sum %0d",
                           side, region_sum);
                    errors++;
                end
                else
                begin
                    want = sums_due.pop_front();
                    if (side !== want.side)
                    begin
                        $error("side: expected %0d, actual %0d", want.side, side);
                        errors++;
                    end
                    if (region_sum !== want.sum)
                    begin
                        $error("region_sum: expected %0d, actual %0d", want.sum, region_sum);
                        errors++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet <= 0;
        else
        begin
            quiet <= quiet + 1;
            if (quiet == QUIET_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    function automatic int draw_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    initial
    begin
        int burst;
        burst = 0;
        forever
        begin
            @(posedge clk);
            if (hold_asks != hold_done)
            begin
                hold_done++;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                burst = 0;
            end
            else if (burst > 0)
            begin
                burst--;
                out_stall <= 1'b1;
            end
            else
            begin
                burst = draw_gap();
                out_stall <= (burst > 0);
                if (burst > 0)
                    burst--;
            end
        end
    end

    function automatic pix_set_t pix4(input int a, input int b, input int c, input int d);
        return {PIX_W'(d), PIX_W'(c), PIX_W'(b), PIX_W'(a)};
    endfunction

    function automatic logic [CFG_DATA_W-1:0] draw_word();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2, 3:    return CFG_DATA_W'($urandom_range(0, 2000));
            default: return CFG_DATA_W'($urandom);
        endcase
    endfunction

    function automatic row_t reg_row(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        row_t r;
        r      = '0;
        r.kind = ROW_REG;
        r.idx  = idx;
        r.val  = val;
        return r;
    endfunction

    function automatic row_t pkt_row(input int n_sync, input logic broken, input pix_set_t lp,
                                     input pix_set_t rp, input logic [BYTE_W-1:0] fill,
                                     input logic rnd_fill, input logic typed,
                                     input int left_sum, input int right_sum);
        row_t r;
        r           = '0;
        r.kind      = ROW_PKT;
        r.n_sync    = 4'(n_sync);
        r.broken    = broken;
        r.left_pix  = lp;
        r.right_pix = rp;
        r.fill      = fill;
        r.rnd_fill  = rnd_fill;
        r.typed     = typed;
        r.left_sum  = SUM_W'(left_sum);
        r.right_sum = SUM_W'(right_sum);
        return r;
    endfunction

    task automatic queue_packet(input row_t r);
        feed_t            f;
        logic [PIX_W-1:0] px;
        int               lo;
        f = '0;
        if (r.broken)
        begin
            f.data = shadow.sync_byte;
            repeat (PREAMBLE_LEN - 1) feed_q.push_back(f);
            f.data = ~shadow.sync_byte;
            feed_q.push_back(f);
        end
        f.data = shadow.sync_byte;
        repeat (r.n_sync) feed_q.push_back(f);
        for (int s = 0; s < 2; s++)
        begin
            for (int i = 0; i < FRAME_BYTES; i++)
            begin
                f      = '0;
                f.data = r.rnd_fill ? BYTE_W'($urandom) : r.fill;
                for (int k = 0; k < 4; k++)
                begin
                    px = s ? r.right_pix[k] : r.left_pix[k];
                    lo = 2 * REGION_PIXEL[k] + 2;
                    if (i == lo)
                        f.data = px[7:0];
                    if (i == lo + 1)
                        f.data = px[15:8];
                end
                if (r.typed && i == FRAME_BYTES - 1)
                begin
                    f.typed     = 1'b1;
                    f.want.side = s[0];
                    f.want.sum  = s ? r.right_sum : r.left_sum;
                end
                feed_q.push_back(f);
            end
        end
        f = '0;
        repeat (TAIL_BYTES)
        begin
            f.data = r.rnd_fill ? BYTE_W'($urandom) : r.fill;
            feed_q.push_back(f);
        end
    endtask

    task automatic push_byte(input feed_t f);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= f.data;
        offer     <= f;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic send_queued();
        while (feed_q.size() != 0)
            push_byte(feed_q.pop_front());
    endtask

    task automatic drain(input int extra);
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sums_due.size() != 0);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        row_t     r;
        feed_t    f;
        pix_set_t lp;
        pix_set_t rp;
        int       base_bytes;
        int       phase_no;
        int       roll;
        int       v;
        int       lim;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        dir_rows = '{
            pkt_row(5, 0, pix4(100, 200, 300, 400), pix4(0, 0, 0, 0), 8'h00, 0, 1, 1000, 0),
            pkt_row(5, 0, pix4(899, 900, 0, 0), pix4(65535, 1, 2, 3), 8'hFF, 0, 1, 1199, 306),
            pkt_row(5, 1, pix4(1, 2, 3, 4), pix4(10, 20, 30, 40), 8'h11, 0, 1, 10, 100),
            pkt_row(7, 0, pix4(5, 5, 5, 5), pix4(6, 6, 6, 6), 8'h00, 0, 0, 0, 0),
            pkt_row(5, 0, pix4(1, 1, 899, 900), pix4(899, 0, 0, 0), 8'd242, 0, 1, 1201, 899),
            pkt_row(5, 1, pix4(7, 7, 7, 7), pix4(8, 8, 8, 8), 8'h11, 0, 1, 28, 32),
            reg_row(CFG_HOT_LIMIT, 16'h0000),
            reg_row(CFG_HOT_SUBST, 16'hFFFF),
            pkt_row(5, 0, pix4(0, 1, 2, 3), pix4(65535, 65535, 65535, 65535), 8'h22, 0, 1,
                    262140, 262140),
            reg_row(CFG_HOT_LIMIT, 16'hFFFF),
            pkt_row(5, 0, pix4(65534, 65534, 65534, 65534), pix4(65535, 0, 0, 0), 8'h33, 0, 1,
                    262136, 65535),
            reg_row(CFG_SYNC_BYTE, 16'hAB5A),
            reg_row(CFG_HOT_SUBST, 16'h0000),
            reg_row(CFG_SPARE, 16'h00F2),
            pkt_row(5, 0, pix4(65535, 7, 8, 9), pix4(100, 100, 100, 100), 8'd242, 0, 1, 24, 400),
            reg_row(CFG_SYNC_BYTE, 16'h0000),
            reg_row(CFG_HOT_LIMIT, 16'd1000),
            reg_row(CFG_HOT_SUBST, 16'd500),
            pkt_row(5, 0, pix4(0, 0, 0, 0), pix4(999, 1000, 1001, 0), 8'h00, 0, 1, 0, 1999),
            reg_row(CFG_SYNC_BYTE, 16'h00FF),
            reg_row(CFG_HOT_LIMIT, 16'd900),
            reg_row(CFG_HOT_SUBST, 16'd300),
            pkt_row(5, 0, pix4(1234, 900, 899, 65535), pix4(50000, 12, 901, 300), 8'h00, 1, 0,
                    0, 0)
        };

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_REG)
            begin
                drain(SETTLE);
                write_reg(dir_rows[i].idx, dir_rows[i].val);
            end
            else
            begin
                queue_packet(dir_rows[i]);
                send_queued();
            end
        end

        base_bytes   = bytes_taken;
        phase_no     = 0;
        while (bytes_taken - base_bytes < RAND_BYTES)
        begin
            drain(SETTLE);
            calm = 1'b0;
            case ($urandom_range(0, 5))
                0:       v = 0;
                1:       v = 255;
                2, 3:    v = SYNC_BYTE_RST;
                default: v = $urandom_range(0, 255);
            endcase
            write_reg(CFG_SYNC_BYTE, {8'($urandom), 8'(v)});
            write_reg(CFG_HOT_LIMIT, draw_word());
            write_reg(CFG_HOT_SUBST, draw_word());
            if ($urandom_range(0, 7) == 0)
                write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
            calm = (phase_no == 0) || ($urandom_range(0, 4) == 0);
            // fill the block behind a stalled receiver
            if (phase_no == 0 || $urandom_range(0, 7) == 0)
                hold_asks++;
            lim = shadow.hot_limit;
            repeat ($urandom_range(1, 4))
            begin
                roll = (phase_no == 0) ? 0 : $urandom_range(0, 19);
                if (roll == 19)
                begin
                    f = '0;
                    repeat ($urandom_range(1, 20))
                    begin
                        f.data = BYTE_W'($urandom);
                        feed_q.push_back(f);
                    end
                end
                else
                begin
                    for (int s = 0; s < 2; s++)
                    begin
                        for (int k = 0; k < 4; k++)
                        begin
                            case ($urandom_range(0, 9))
                                0, 1, 2: v = $urandom_range(0, 65535);
                                3, 4, 5: v = lim - 2 + $urandom_range(0, 3);
                                6, 7:    v = $urandom_range(0, 1000);
                                8:       v = 65535;
                                default: v = 0;
                            endcase
                            if (v < 0)
                                v = 0;
                            if (v > 65535)
                                v = 65535;
                            if (s == 0)
                                lp[k] = PIX_W'(v);
                            else
                                rp[k] = PIX_W'(v);
                        end
                    end
                    r = pkt_row((roll == 15 || roll == 16) ? roll - 9 : PREAMBLE_LEN,
                                (roll == 17 || roll == 18), lp, rp,
                                ($urandom_range(0, 1) != 0) ? shadow.sync_byte : BYTE_W'($urandom),
                                ($urandom_range(0, 3) != 0), 1'b0, 0, 0);
                    queue_packet(r);
                end
            end
            send_queued();
            phase_no++;
        end

        calm = 1'b0;
        drain(SETTLE);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/thfra_pkg.sv
rtl/thfra_cfg.sv
rtl/thfra_in_reg.sv
rtl/thfra_core.sv
rtl/thermal_frame_region_average.sv
tb/thermal_frame_region_average_test.sv
